// ===== hw/rtl/spq_pkg.sv =====
// Shared types and constants for the stable priority queue.
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

  localparam int DEPTH     = 16;
  localparam int PAYLOAD_W = 32;
  localparam int PRIO_W    = 8;
  localparam int SEQ_W     = 32;
  localparam int CAP_W     = 5;
  localparam int OCC_W     = 5;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int ENTRY_W   = PRIO_W + PAYLOAD_W + SEQ_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic [SEQ_W-1:0] SEQ_START = SEQ_W'(1);

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic MODE_PUSH = 1'b0;

  typedef struct packed {
    logic [PRIO_W-1:0]    prio;
    logic [PAYLOAD_W-1:0] payload;
    logic [SEQ_W-1:0]     seq;
  } entry_t;

  typedef struct packed {
    logic load;
    logic push;
    logic refuse_full;
    logic refuse_empty;
    logic scan_start;
    logic scan;
    logic shift_init;
    logic shift;
    logic pop_done;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mode;
    logic full;
    logic empty;
    logic done;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/spq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/spq_datapath.sv =====
// Datapath: entry store, count, sequence counter, scan and shift pointers, result register.
`timescale 1ns / 1ps
`default_nettype none
module spq_datapath (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_valid,
  input  wire logic [spq_pkg::CAP_W-1:0] cfg_data,
  input  wire logic                    in_tuser,
  input  wire logic [39:0]             in_tdata,
  input  wire spq_pkg::ctrl_cmd_t      cmd,
  output spq_pkg::dp_stat_t            stat,
  output logic      [1:0]              out_tuser,
  output logic      [79:0]             out_tdata
);
  import spq_pkg::*;

  logic [CAP_W-1:0]     cap_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [SEQ_W-1:0]     seq_r;
  logic                 op_mode_r;
  logic [PRIO_W-1:0]    op_prio_r;
  logic [PAYLOAD_W-1:0] op_pay_r;
  logic [CNT_W-1:0]     rd_ptr_r;
  logic [IDX_W-1:0]     wr_ptr_r;
  logic [IDX_W-1:0]     cmp_idx_r;
  logic                 pend_r;
  entry_t               best_r;
  logic [IDX_W-1:0]     best_idx_r;

  logic [1:0]           res_status_r;
  logic [PRIO_W-1:0]    res_prio_r;
  logic [PAYLOAD_W-1:0] res_pay_r;
  logic [SEQ_W-1:0]     res_seq_r;
  logic [OCC_W-1:0]     res_occ_r;

  logic                 rd_go;
  logic                 we;
  logic [IDX_W-1:0]     waddr;
  entry_t               wentry;
  entry_t               rdata;
  logic [CMP_W-1:0]     eff_cap;
  logic [CNT_W-1:0]     cnt_dec;

  assign rd_go = (cmd.scan || cmd.shift) && (rd_ptr_r != cnt_r);
  assign cnt_dec = cnt_r - CNT_W'(1);

  always_comb begin
    we     = 1'b0;
    waddr  = wr_ptr_r;
    wentry = rdata;
    if (cmd.push) begin
      we     = 1'b1;
      waddr  = cnt_r[IDX_W-1:0];
      wentry = '{prio: op_prio_r, payload: op_pay_r, seq: seq_r};
    end else if (cmd.shift && pend_r) begin
      we = 1'b1;
    end
  end

  always_comb begin
    if (CMP_W'(cap_r) > CMP_W'(DEPTH)) begin
      eff_cap = CMP_W'(DEPTH);
    end else begin
      eff_cap = CMP_W'(cap_r);
    end
  end

  assign stat.mode  = op_mode_r;
  assign stat.full  = CMP_W'(cnt_r) >= eff_cap;
  assign stat.empty = cnt_r == '0;
  assign stat.done  = (rd_ptr_r == cnt_r) && !pend_r;

  spq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wentry),
    .re   (rd_go),
    .raddr(rd_ptr_r[IDX_W-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_RESET;
      cnt_r  <= '0;
      seq_r  <= SEQ_START;
      pend_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
      if (cmd.scan_start) begin
        pend_r <= 1'b0;
      end else if (cmd.shift_init) begin
        pend_r <= 1'b0;
      end else if (cmd.scan || cmd.shift) begin
        pend_r <= rd_go;
      end
      if (cmd.push) begin
        cnt_r <= cnt_r + CNT_W'(1);
        seq_r <= seq_r + SEQ_W'(1);
      end else if (cmd.pop_done) begin
        cnt_r <= cnt_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_mode_r <= in_tuser;
      op_prio_r <= in_tdata[7:0];
      op_pay_r  <= in_tdata[8 +: PAYLOAD_W];
    end
    if (cmd.scan_start) begin
      rd_ptr_r <= '0;
    end else if (cmd.shift_init) begin
      rd_ptr_r <= CNT_W'(best_idx_r) + CNT_W'(1);
      wr_ptr_r <= best_idx_r;
    end else if (cmd.scan || cmd.shift) begin
      rd_ptr_r  <= rd_ptr_r + CNT_W'(rd_go);
      cmp_idx_r <= rd_ptr_r[IDX_W-1:0];
    end
    // first entry seeds the best; later ones replace it only on strictly higher priority
    if (cmd.scan && pend_r && (cmp_idx_r == '0 || rdata.prio > best_r.prio)) begin
      best_r     <= rdata;
      best_idx_r <= cmp_idx_r;
    end
    if (cmd.shift && pend_r) begin
      wr_ptr_r <= wr_ptr_r + IDX_W'(1);
    end
    if (cmd.push) begin
      res_status_r <= ST_DONE;
      res_prio_r   <= '0;
      res_pay_r    <= '0;
      res_seq_r    <= seq_r;
      res_occ_r    <= OCC_W'(cnt_r + CNT_W'(1));
    end
    if (cmd.refuse_full || cmd.refuse_empty) begin
      res_status_r <= cmd.refuse_full ? ST_FULL : ST_EMPTY;
      res_prio_r   <= '0;
      res_pay_r    <= '0;
      res_seq_r    <= '0;
      res_occ_r    <= OCC_W'(cnt_r);
    end
    if (cmd.pop_done) begin
      res_status_r <= ST_DONE;
      res_prio_r   <= best_r.prio;
      res_pay_r    <= best_r.payload;
      res_seq_r    <= best_r.seq;
      res_occ_r    <= OCC_W'(cnt_dec);
    end
  end

  assign out_tuser = res_status_r;
  assign out_tdata = {3'b000, res_occ_r, res_seq_r, 32'(res_pay_r), res_prio_r};

endmodule
`default_nettype wire

// ===== hw/rtl/spq_ctrl.sv =====
// Controller: sequences push, scan, shift and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module spq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  input  wire spq_pkg::dp_stat_t  stat,
  output spq_pkg::ctrl_cmd_t      cmd
);
  import spq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_POP,
    S_SCAN,
    S_SHIFT,
    S_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   ofree;
  logic   finish;

  assign ofree     = !out_valid_r || out_tready;
  assign in_tready = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;
  assign finish    = cmd.push || cmd.refuse_full || cmd.refuse_empty || cmd.pop_done;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        cmd.load = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (stat.mode != MODE_PUSH) begin
          state_nxt = S_POP;
        end else if (ofree) begin
          cmd.push        = !stat.full;
          cmd.refuse_full = stat.full;
          state_nxt       = S_IDLE;
        end
      end
      S_POP: begin
        if (!stat.empty) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end else if (ofree) begin
          cmd.refuse_empty = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.done) begin
          cmd.shift_init = 1'b1;
          state_nxt      = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (stat.done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (ofree) begin
          cmd.pop_done = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/stable_priority_queue_top.sv =====
// Top level of the stable priority queue: controller plus datapath.
//
//   channel | dir | handshake             | contents
//   in      | in  | in_tvalid/in_tready   | tuser: mode; tdata: priority, payload
//   out     | out | out_tvalid/out_tready | tuser: status; tdata: priority, payload,
//           |     |                       |   sequence, occupancy
//   cfg     | in  | cfg_valid/cfg_ready   | cfg_data: capacity_in_use
//
// A push goes from acceptance to its result without a scan. A pop of N entries
// with the winner at index b runs a linear scan and then a shift loop over the one-write,
// one-read entry store that moves the entries behind b down by one, none when b is the last.
// An empty pop is refused without a scan.
// One transaction in flight; the next is accepted while the result waits.
// Synchronous active-low reset; the store itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module stable_priority_queue_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic        in_tuser,   // [0] mode
  input  wire logic [39:0] in_tdata,   // [7:0] in_priority, [39:8] in_payload
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [1:0]  out_tuser,  // [1:0] status
  output logic      [79:0] out_tdata,  // [7:0] out_priority, [39:8] out_payload,
                                       // [71:40] out_sequence, [76:72] occupancy
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_data
);
  import spq_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  spq_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .in_tuser (in_tuser),
    .in_tdata (in_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .out_tuser(out_tuser),
    .out_tdata(out_tdata)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/spq_checker.sv =====
// Port-level checker for the stable priority queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module spq_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [1:0]  out_tuser,
  input wire logic [79:0] out_tdata
);
  import spq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_DONE || out_tuser == ST_FULL || out_tuser == ST_EMPTY))
    else $error("bad status code");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_DONE |-> out_tdata[71:0] == '0)
    else $error("refused transaction carries data");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_EMPTY |-> out_tdata[76:72] == '0)
    else $error("empty status with nonzero occupancy");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[76:72] <= 5'(DEPTH))
    else $error("occupancy beyond depth");

endmodule

bind stable_priority_queue_top spq_checker u_spq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tuser (out_tuser),
  .out_tdata (out_tdata)
);
`default_nettype wire
